// ----- rtl/tsg_pkg.sv -----
// Shared types, command codes and constants for the tone sequence generator.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package tsg_pkg;

  localparam int FREQ_W     = 14;
  localparam int HALF_W     = 13;
  localparam int DIVIDEND_W = 19;
  localparam int DIV_STEPS  = DIVIDEND_W;

  localparam logic [FREQ_W-1:0]     FREQ_MIN = 14'd100;
  localparam logic [FREQ_W-1:0]     FREQ_MAX = 14'd10000;
  localparam logic [DIVIDEND_W-1:0] HALF_NUM = 19'd500000;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_BEEP = 3'd1;
  localparam logic [2:0] CMD_LOAD = 3'd2;
  localparam logic [2:0] CMD_PLAY = 3'd3;
  localparam logic [2:0] CMD_STOP = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  elapsed_us;
    logic [15:0] frequency;
    logic [31:0] duration_ms;
    logic [3:0]  note_slot;
    logic [4:0]  note_count;
  } tsg_in_t;

  typedef struct packed {
    logic       buzzer_level;
    logic       tone_active;
    logic       sequence_active;
    logic [3:0] current_note;
  } tsg_out_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [31:0]       dur;
  } tsg_note_t;

  function automatic logic [FREQ_W-1:0] clamp_freq(input logic [15:0] f);
    logic [FREQ_W-1:0] r;
    if (f < 16'(FREQ_MIN)) r = FREQ_MIN;
    else if (f > 16'(FREQ_MAX)) r = FREQ_MAX;
    else r = f[FREQ_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/tsg_divider.sv -----
// Restoring serial divider: half period = 500000 / frequency, one bit per cycle.
// Depends on tsg_pkg for widths and the dividend constant.
`timescale 1ns / 1ps

module tsg_divider
  import tsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FREQ_W-1:0] divisor,
  output logic              done,
  output logic [HALF_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [FREQ_W-1:0]     dvs_r, dvs_nxt;
  logic [FREQ_W-1:0]     rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [FREQ_W:0]       trial;
  logic                  ge;

  assign trial = {rem_r, q_r[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = HALF_NUM;
    end else if (busy_r) begin
      // shift the next dividend bit in, subtract when it fits
      rem_nxt = ge ? FREQ_W'(trial - {1'b0, dvs_r}) : trial[FREQ_W-1:0];
      q_nxt   = {q_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[HALF_W-1:0];

endmodule

// ----- rtl/tone_sequence_generator.sv -----
// Top level of the tone sequence generator: command sequencer, clocks, note table.
// Depends on tsg_pkg and instantiates tsg_divider.
`timescale 1ns / 1ps

// One command is taken at a time and gives one result. A load, stop or idle tick
// goes from rest straight to the result state; a tick that checks a running tone
// passes through the check state and, while the tone goes on, the wave state. A
// beep, a play sequence, and a tick that moves a sequence to its next note start
// a new tone and wait in the divide state for the serial divider, which computes
// the half period one quotient bit per cycle. The note table is a memory with one
// write port and one registered read port, NOTE_SLOTS entries deep, and holds no
// defined contents until loaded.
// The input side is taken again as soon as the sequencer is back at rest, even
// while the previous result still waits in the output register.

module tone_sequence_generator
  import tsg_pkg::*;
#(
  parameter int NOTE_SLOTS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tsg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tsg_out_t out_data
);

  localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NOTE_SLOTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_NOTE  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WAVE  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       micro_r, micro_nxt;
  logic [9:0]        pre_r, pre_nxt;
  logic [31:0]       milli_r, milli_nxt;
  logic [31:0]       tone_start_r, tone_start_nxt;
  logic [31:0]       tone_len_r, tone_len_nxt;
  logic [31:0]       last_tog_r, last_tog_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic              pin_r, pin_nxt;
  logic              tone_on_r, tone_on_nxt;
  logic              seq_on_r, seq_on_nxt;
  logic [CNT_W-1:0]  seq_pos_r, seq_pos_nxt;
  logic [CNT_W-1:0]  seq_len_r, seq_len_nxt;
  logic [31:0]       seq_start_r, seq_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  tsg_out_t          out_data_r, out_data_nxt;

  tsg_note_t         note_mem [NOTE_SLOTS];
  tsg_note_t         rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  logic              div_start;
  logic [FREQ_W-1:0] div_divisor;
  logic              div_done;
  logic [HALF_W-1:0] div_quotient;

  logic              in_xfer;
  logic [10:0]       pre_sum;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  cnt_sat;
  logic [FREQ_W-1:0] in_freq_c;

  tsg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign in_xfer   = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign pre_sum   = 11'(pre_r) + 11'(in_data.elapsed_us);
  assign pos_inc   = seq_pos_r + CNT_W'(1);
  assign in_freq_c = clamp_freq(in_data.frequency);
  assign cnt_sat   = ({27'd0, in_data.note_count} > 32'(NOTE_SLOTS)) ?
                     CNT_W'(NOTE_SLOTS) : CNT_W'(in_data.note_count);

  always_comb begin
    state_nxt      = state_r;
    micro_nxt      = micro_r;
    pre_nxt        = pre_r;
    milli_nxt      = milli_r;
    tone_start_nxt = tone_start_r;
    tone_len_nxt   = tone_len_r;
    last_tog_nxt   = last_tog_r;
    half_nxt       = half_r;
    pin_nxt        = pin_r;
    tone_on_nxt    = tone_on_r;
    seq_on_nxt     = seq_on_r;
    seq_pos_nxt    = seq_pos_r;
    seq_len_nxt    = seq_len_r;
    seq_start_nxt  = seq_start_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_addr        = IDX_W'(seq_pos_r);
    mem_we         = 1'b0;
    div_start      = 1'b0;
    div_divisor    = in_freq_c;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_FIN;
          case (in_data.command)
            CMD_TICK: begin
              micro_nxt = micro_r + 32'(in_data.elapsed_us);
              if (pre_sum >= 11'd2000) begin
                pre_nxt   = 10'(pre_sum - 11'd2000);
                milli_nxt = milli_r + 32'd2;
              end else if (pre_sum >= 11'd1000) begin
                pre_nxt   = 10'(pre_sum - 11'd1000);
                milli_nxt = milli_r + 32'd1;
              end else begin
                pre_nxt = pre_sum[9:0];
              end
              // table read at the current position is issued now
              if (seq_on_r || tone_on_r) state_nxt = ST_CHECK;
            end
            CMD_BEEP: begin
              tone_len_nxt   = in_data.duration_ms;
              tone_start_nxt = milli_r;
              tone_on_nxt    = 1'b1;
              pin_nxt        = 1'b0;
              last_tog_nxt   = micro_r;
              div_start      = 1'b1;
              state_nxt      = ST_DIV;
            end
            CMD_LOAD: begin
              if ({28'd0, in_data.note_slot} < 32'(NOTE_SLOTS)) mem_we = 1'b1;
            end
            CMD_PLAY: begin
              if (in_data.note_count != 5'd0) begin
                seq_len_nxt = cnt_sat;
                seq_pos_nxt = '0;
                seq_on_nxt  = 1'b1;
                rd_addr     = '0;
                state_nxt   = ST_NOTE;
              end
            end
            CMD_STOP: begin
              tone_on_nxt = 1'b0;
              seq_on_nxt  = 1'b0;
              pin_nxt     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        state_nxt = ST_FIN;
        if (seq_on_r) begin
          if ((milli_r - seq_start_r) >= rd_data_r.dur) begin
            seq_pos_nxt = pos_inc;
            if (pos_inc >= seq_len_r) begin
              tone_on_nxt = 1'b0;
              seq_on_nxt  = 1'b0;
              pin_nxt     = 1'b0;
            end else begin
              rd_addr   = IDX_W'(pos_inc);
              state_nxt = ST_NOTE;
            end
          end else if (tone_on_r) begin
            state_nxt = ST_WAVE;
          end
        end else if (tone_on_r) begin
          if ((milli_r - tone_start_r) >= tone_len_r) begin
            tone_on_nxt = 1'b0;
            seq_on_nxt  = 1'b0;
            pin_nxt     = 1'b0;
          end else begin
            state_nxt = ST_WAVE;
          end
        end
      end
      ST_NOTE: begin
        // new note: a fresh tone never toggles in the same update
        tone_len_nxt   = rd_data_r.dur;
        tone_start_nxt = milli_r;
        tone_on_nxt    = 1'b1;
        pin_nxt        = 1'b0;
        last_tog_nxt   = micro_r;
        seq_start_nxt  = milli_r;
        div_start      = 1'b1;
        div_divisor    = rd_data_r.freq;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          half_nxt  = div_quotient;
          state_nxt = ST_FIN;
        end
      end
      ST_WAVE: begin
        if ((micro_r - last_tog_r) >= 32'(half_r)) begin
          last_tog_nxt = micro_r;
          pin_nxt      = !pin_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.buzzer_level    = pin_r;
          out_data_nxt.tone_active     = tone_on_r;
          out_data_nxt.sequence_active = seq_on_r;
          out_data_nxt.current_note    = seq_on_r ? 4'(seq_pos_r) : 4'd0;
          state_nxt                    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[IDX_W'(in_data.note_slot)] <= '{freq: in_freq_c, dur: in_data.duration_ms};
    end
    rd_data_r <= note_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      micro_r      <= '0;
      pre_r        <= '0;
      milli_r      <= '0;
      tone_start_r <= '0;
      tone_len_r   <= '0;
      last_tog_r   <= '0;
      half_r       <= '0;
      pin_r        <= 1'b0;
      tone_on_r    <= 1'b0;
      seq_on_r     <= 1'b0;
      seq_pos_r    <= '0;
      seq_len_r    <= '0;
      seq_start_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      micro_r      <= micro_nxt;
      pre_r        <= pre_nxt;
      milli_r      <= milli_nxt;
      tone_start_r <= tone_start_nxt;
      tone_len_r   <= tone_len_nxt;
      last_tog_r   <= last_tog_nxt;
      half_r       <= half_nxt;
      pin_r        <= pin_nxt;
      tone_on_r    <= tone_on_nxt;
      seq_on_r     <= seq_on_nxt;
      seq_pos_r    <= seq_pos_nxt;
      seq_len_r    <= seq_len_nxt;
      seq_start_r  <= seq_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("sequencer stayed at rest after an input transfer");

  // the first note's tone starts in the cycle after the sequence flag rises
  a_seq_implies_tone: assert property (@(posedge clk) disable iff (!rst_n)
    seq_on_r && (state_r != ST_NOTE) |-> tone_on_r)
    else $error("sequence running without a tone");

  a_seq_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_on_r |-> (seq_pos_r < seq_len_r))
    else $error("sequence position beyond sequence length");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the wait state");

  a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
    pre_r < 10'd1000)
    else $error("millisecond prescaler out of range");

endmodule
